// ===== sv/itd_pkg.sv =====
// ----------------------------------------------------------------------------
// itd_pkg: shared types and constants
// Field widths, time constants, operation and register codes of the interval
// timer.
// ----------------------------------------------------------------------------
package itd_pkg;

  localparam int SEC_W   = 27;
  localparam int USEC_W  = 20;
  localparam int INDEX_W = 3;
  localparam int DATA_W  = SEC_W;

  // one second in microseconds, one bit wider than a micros field
  localparam logic [USEC_W:0]  USEC_PER_SEC = (USEC_W + 1)'(1000000);
  localparam logic [USEC_W-1:0] MAX_MICROS  = USEC_W'(999999);
  localparam logic [SEC_W-1:0]  MAX_SECONDS = SEC_W'(100000000);

  // request operations
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_START_SECONDS     = INDEX_W'(0);
  localparam logic [INDEX_W-1:0] REG_START_MICROS      = INDEX_W'(1);
  localparam logic [INDEX_W-1:0] REG_PERIOD_SECONDS    = INDEX_W'(2);
  localparam logic [INDEX_W-1:0] REG_PERIOD_MICROS     = INDEX_W'(3);
  localparam logic [INDEX_W-1:0] REG_CLOCK_TICK_MICROS = INDEX_W'(4);

  localparam logic [USEC_W-1:0] TICK_RESET = USEC_W'(10000);

  typedef struct packed {
    logic [SEC_W-1:0]  sec;
    logic [USEC_W-1:0] usec;
  } timeval_t;

  typedef struct packed {
    timeval_t          start;
    timeval_t          period;
    logic [USEC_W-1:0] tick;
  } cfg_t;

  typedef struct packed {
    logic bad_value;
    logic running;
    logic expired;
  } flags_t;

endpackage

// ===== sv/itd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// itd_cfg_regs: configuration register file
// Holds start value, reload period and clock tick, written by index.
// ----------------------------------------------------------------------------
module itd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [itd_pkg::INDEX_W-1:0] wr_index,
  input  logic [itd_pkg::DATA_W-1:0]  wr_data,
  output itd_pkg::cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start.sec  <= '0;
      cfg.start.usec <= '0;
      cfg.period.sec  <= '0;
      cfg.period.usec <= '0;
      cfg.tick       <= itd_pkg::TICK_RESET;
    end else if (wr_en) begin
      case (wr_index)
        itd_pkg::REG_START_SECONDS:     cfg.start.sec   <= wr_data[itd_pkg::SEC_W-1:0];
        itd_pkg::REG_START_MICROS:      cfg.start.usec  <= wr_data[itd_pkg::USEC_W-1:0];
        itd_pkg::REG_PERIOD_SECONDS:    cfg.period.sec  <= wr_data[itd_pkg::SEC_W-1:0];
        itd_pkg::REG_PERIOD_MICROS:     cfg.period.usec <= wr_data[itd_pkg::USEC_W-1:0];
        itd_pkg::REG_CLOCK_TICK_MICROS: cfg.tick        <= wr_data[itd_pkg::USEC_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/itd_step.sv =====
// ----------------------------------------------------------------------------
// itd_step: timer update logic
// Validates and arms on a load; subtracts, borrows, flags expiry and reloads
// less the overshoot on a tick, or stops at zero for a zero period.
// ----------------------------------------------------------------------------
module itd_step (
  input  logic                      op,
  input  logic [itd_pkg::USEC_W-1:0] elapsed,
  input  itd_pkg::cfg_t             cfg,
  input  itd_pkg::timeval_t         rem,
  input  itd_pkg::timeval_t         armed,
  output itd_pkg::timeval_t         rem_next,
  output itd_pkg::timeval_t         armed_next,
  output itd_pkg::flags_t           flags
);

  localparam int SW = itd_pkg::SEC_W;
  localparam int UW = itd_pkg::USEC_W;

  logic [UW-1:0] tick_c;
  logic [UW-1:0] el_c;
  logic          start_ok;
  logic          period_ok;
  logic          active;
  logic          under;
  logic          borrow;
  logic [UW:0]   dec_us;
  logic [SW-1:0] dec_sec;
  logic [UW-1:0] over;
  logic          hit;
  logic          short_period;
  logic [UW:0]   rel_us;
  logic [SW-1:0] rel_sec;
  itd_pkg::timeval_t tick_val;

  // raise a small nonzero sub-second value to one clock tick
  function automatic logic [UW-1:0] round_up(input logic [SW-1:0] s,
                                            input logic [UW-1:0] us,
                                            input logic [UW-1:0] t);
    if (s == '0 && us != '0 && us < t) begin
      return t;
    end
    return us;
  endfunction

  always_comb begin
    tick_c    = (cfg.tick > itd_pkg::MAX_MICROS) ? itd_pkg::MAX_MICROS : cfg.tick;
    el_c      = (elapsed > itd_pkg::MAX_MICROS) ? itd_pkg::MAX_MICROS : elapsed;
    start_ok  = cfg.start.sec <= itd_pkg::MAX_SECONDS &&
                {1'b0, cfg.start.usec} < itd_pkg::USEC_PER_SEC;
    period_ok = cfg.period.sec <= itd_pkg::MAX_SECONDS &&
                {1'b0, cfg.period.usec} < itd_pkg::USEC_PER_SEC;
    active    = rem.sec != '0 || rem.usec != '0;

    borrow  = rem.usec < el_c;
    under   = borrow && rem.sec == '0;
    dec_us  = {1'b0, rem.usec} + (borrow ? itd_pkg::USEC_PER_SEC : '0) - {1'b0, el_c};
    dec_sec = rem.sec - (borrow ? SW'(1) : SW'(0));
    over    = under ? (el_c - rem.usec) : '0;
    hit     = under || (dec_sec == '0 && dec_us == '0);

    // reload less the overshoot; an overshoot beyond the whole period is dropped
    short_period = armed.usec < over;
    if (short_period && armed.sec == '0) begin
      rel_sec = armed.sec;
      rel_us  = {1'b0, armed.usec};
    end else if (short_period) begin
      rel_sec = armed.sec - SW'(1);
      rel_us  = {1'b0, armed.usec} + itd_pkg::USEC_PER_SEC - {1'b0, over};
    end else begin
      rel_sec = armed.sec;
      rel_us  = {1'b0, armed.usec} - {1'b0, over};
    end

    tick_val.sec  = dec_sec;
    tick_val.usec = dec_us[UW-1:0];

    rem_next        = rem;
    armed_next      = armed;
    flags.expired   = 1'b0;
    flags.bad_value = 1'b0;

    if (op == itd_pkg::OP_LOAD) begin
      if (!start_ok || !period_ok) begin
        flags.bad_value = 1'b1;
      end else begin
        rem_next.sec    = cfg.start.sec;
        rem_next.usec   = round_up(cfg.start.sec, cfg.start.usec, tick_c);
        armed_next.sec  = cfg.period.sec;
        armed_next.usec = round_up(cfg.period.sec, cfg.period.usec, tick_c);
      end
    end else if (active) begin
      if (hit) begin
        flags.expired = 1'b1;
        if (armed.sec != '0 || armed.usec != '0) begin
          rem_next.sec  = rel_sec;
          rem_next.usec = rel_us[UW-1:0];
        end else begin
          rem_next = '0;
        end
      end else begin
        rem_next = tick_val;
      end
    end

    flags.running = rem_next.sec != '0 || rem_next.usec != '0;
  end

endmodule

// ===== sv/interval_timer_decrement.sv =====
// ----------------------------------------------------------------------------
// interval_timer_decrement: seconds and microseconds interval timer
// Periodic timer with reload; load and tick requests in, one status out each.
// ----------------------------------------------------------------------------
// Requests enter on s_axis: tuser selects tick (0) or load (1), tdata carries
// the elapsed microseconds of a tick. A load arms the timer from the start
// and period registers or reports bad_value; a tick counts down, flags
// expiry and reloads from the latched period less the overshoot.
// Each request gives exactly one result on m_axis with the flags in tuser
// and the remaining time in tdata.
// After acceptance the request lands in the input register; the update logic
// then loads the output register whenever that register advances. One
// request is taken every cycle while m_axis does not stall; the timer state
// is updated in the same cycle as the output register, so each request sees
// the previous one's state.
// When m_axis stalls, the output and input registers hold and s_axis_tready
// drops once both are full; nothing is lost.
// Configuration writes on cfg_* are taken every cycle and should only be
// issued while no request is in flight.
// Reset clears the timer to zero, empties both registers and returns the
// configuration to its reset values (clock tick 10000 us).
// ----------------------------------------------------------------------------
module interval_timer_decrement (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // [19:0] elapsed_micros
  input  logic                        s_axis_tuser,  // [0] operation
  // result channel
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [47:0]                 m_axis_tdata,  // [26:0] left_seconds,
                                                     // [46:27] left_micros
  output logic [2:0]                  m_axis_tuser,  // [0] expired, [1] running,
                                                     // [2] bad_value
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [itd_pkg::INDEX_W-1:0] cfg_index,
  input  logic [itd_pkg::DATA_W-1:0]  cfg_data
);

  localparam int UW = itd_pkg::USEC_W;

  itd_pkg::cfg_t     cfg;
  logic              in_valid;
  logic              in_op;
  logic [UW-1:0]     in_elapsed;
  logic              advance;
  itd_pkg::timeval_t rem;
  itd_pkg::timeval_t armed;
  itd_pkg::timeval_t rem_next;
  itd_pkg::timeval_t armed_next;
  itd_pkg::flags_t   flags_next;
  itd_pkg::flags_t   out_flags;
  itd_pkg::timeval_t out_time;
  logic              out_valid;

  assign cfg_ready = 1'b1;

  itd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  itd_step u_step (
    .op         (in_op),
    .elapsed    (in_elapsed),
    .cfg        (cfg),
    .rem        (rem),
    .armed      (armed),
    .rem_next   (rem_next),
    .armed_next (armed_next),
    .flags      (flags_next)
  );

  // the output register moves whenever it is empty or being taken
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_op      <= s_axis_tuser;
      in_elapsed <= s_axis_tdata[UW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rem       <= '0;
      armed     <= '0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        rem   <= rem_next;
        armed <= armed_next;
      end
    end
    if (advance && in_valid) begin
      out_flags <= flags_next;
      out_time  <= rem_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = {out_flags.bad_value, out_flags.running, out_flags.expired};
  assign m_axis_tdata  = {1'b0, out_time.usec, out_time.sec};

endmodule

// ===== sim/itd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// itd_checker: result checker for the interval timer
// Watches the request, result and configuration channels, keeps its own copy
// of the timer and its registers, predicts one status per accepted request
// and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module itd_checker
  import itd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,  // [19:0] elapsed_micros
  input  logic               s_axis_tuser,  // [0] operation
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [47:0]        m_axis_tdata,  // [26:0] left_seconds, [46:27] left_micros
  input  logic [2:0]         m_axis_tuser,  // [0] expired, [1] running, [2] bad_value
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]  cfg_data,
  output int unsigned        fail_count,
  output int unsigned        pending_count
);

  typedef struct packed {
    logic              expired;
    logic              running;
    logic              bad_value;
    logic [SEC_W-1:0]  left_seconds;
    logic [USEC_W-1:0] left_micros;
  } timer_status_t;

  cfg_t          regs;
  timeval_t      remaining;
  timeval_t      armed_period;
  timer_status_t due_status[$];

  initial fail_count = 0;

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic in_range(input timeval_t v);
    return v.sec <= MAX_SECONDS && {1'b0, v.usec} < USEC_PER_SEC;
  endfunction

  // round a nonzero sub-tick value up to the clock tick
  function automatic logic [USEC_W-1:0] tick_rounded(input timeval_t v);
    logic [USEC_W-1:0] tick_eff;
    tick_eff = (regs.tick > MAX_MICROS) ? MAX_MICROS : regs.tick;
    if (v.sec == '0 && v.usec != '0 && v.usec < tick_eff)
      return tick_eff;
    return v.usec;
  endfunction

  task automatic advance_timer(input logic op, input logic [USEC_W-1:0] elapsed);
    int unsigned   s, us, ps, pus, el, over;
    logic          hit;
    timer_status_t st;
    st = '0;
    over = 0;
    hit = 1'b0;
    el = elapsed;
    if (op == OP_LOAD) begin
      if (!in_range(regs.start) || !in_range(regs.period)) begin
        st.bad_value = 1'b1;
      end else begin
        remaining.sec     = regs.start.sec;
        remaining.usec    = tick_rounded(regs.start);
        armed_period.sec  = regs.period.sec;
        armed_period.usec = tick_rounded(regs.period);
      end
    end else if (remaining != '0) begin
      s = remaining.sec;
      us = remaining.usec;
      if (el > MAX_MICROS) el = MAX_MICROS;
      if (us < el && s == 0) begin
        over = el - us;
        hit = 1'b1;
      end else begin
        // borrow a second
        if (us < el) begin
          us += USEC_PER_SEC;
          s -= 1;
        end
        us -= el;
        hit = (s == 0 && us == 0);
      end
      if (hit) begin
        st.expired = 1'b1;
        if (armed_period != '0) begin
          ps = armed_period.sec;
          pus = armed_period.usec;
          if (pus < over) begin
            // overshoot beyond a sub-second period: reload the full period
            if (ps == 0) begin
              over = 0;
            end else begin
              pus += USEC_PER_SEC;
              ps -= 1;
            end
          end
          s = ps;
          us = pus - over;
        end else begin
          s = 0;
          us = 0;
        end
      end
      remaining.sec  = s[SEC_W-1:0];
      remaining.usec = us[USEC_W-1:0];
    end
    st.running      = (remaining != '0);
    st.left_seconds = remaining.sec;
    st.left_micros  = remaining.usec;
    due_status.push_back(st);
  endtask

  always @(posedge clk) begin
    timer_status_t want;
    if (rst) begin
      regs.start   <= '0;
      regs.period  <= '0;
      regs.tick    <= TICK_RESET;
      remaining    <= '0;
      armed_period <= '0;
      due_status.delete();
      pending_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_SECONDS:     regs.start.sec   = cfg_data[SEC_W-1:0];
          REG_START_MICROS:      regs.start.usec  = cfg_data[USEC_W-1:0];
          REG_PERIOD_SECONDS:    regs.period.sec  = cfg_data[SEC_W-1:0];
          REG_PERIOD_MICROS:     regs.period.usec = cfg_data[USEC_W-1:0];
          REG_CLOCK_TICK_MICROS: regs.tick        = cfg_data[USEC_W-1:0];
          default: ;
        endcase
      end
      // retire the result first: it can never belong to this edge's request
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_status.size() == 0) begin
          report_error("result with no request outstanding");
        end else begin
          want = due_status.pop_front();
          if (m_axis_tuser[0] !== want.expired)
            report_error($sformatf("expired: expected %0d got %0d",
                                   want.expired, m_axis_tuser[0]));
          if (m_axis_tuser[1] !== want.running)
            report_error($sformatf("running: expected %0d got %0d",
                                   want.running, m_axis_tuser[1]));
          if (m_axis_tuser[2] !== want.bad_value)
            report_error($sformatf("bad_value: expected %0d got %0d",
                                   want.bad_value, m_axis_tuser[2]));
          if (m_axis_tdata[26:0] !== want.left_seconds)
            report_error($sformatf("left_seconds: expected %0d got %0d",
                                   want.left_seconds, m_axis_tdata[26:0]));
          if (m_axis_tdata[46:27] !== want.left_micros)
            report_error($sformatf("left_micros: expected %0d got %0d",
                                   want.left_micros, m_axis_tdata[46:27]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        advance_timer(s_axis_tuser, s_axis_tdata[USEC_W-1:0]);
      pending_count <= due_status.size();
    end
  end

endmodule

// ===== sim/tb_interval_timer_decrement.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interval_timer_decrement: testbench for the interval timer
// Drives load and tick requests in random bursts against a stalling result
// sink, with directed corner cases first and randomised configuration
// phases after; the checker predicts and compares every status.
// ----------------------------------------------------------------------------
module tb_interval_timer_decrement;
  import itd_pkg::*;

  localparam int RANDOM_ITEMS = 1750;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata = '0;
  logic               s_axis_tuser = OP_TICK;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [47:0]        m_axis_tdata;
  logic [2:0]         m_axis_tuser;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [INDEX_W-1:0] cfg_index = REG_START_SECONDS;
  logic [DATA_W-1:0]  cfg_data = '0;
  int unsigned        fail_count;
  int unsigned        pending_count;

  int unsigned burst_left = 0;
  int unsigned sink_mode = 0;
  int unsigned sink_left = 0;
  int unsigned sink_cycle = 0;

  interval_timer_decrement i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  itd_checker i_chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("** interval_timer_decrement: FAILED **");
    $finish;
  end

  // result sink: switch between randomly chosen stall patterns
  always @(posedge clk) begin
    sink_cycle <= sink_cycle + 1;
    if (sink_left == 0) begin
      sink_mode <= $urandom_range(3);
      sink_left <= $urandom_range(20, 120);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(3) != 0);
      2: m_axis_tready <= ($urandom_range(3) == 0);
      default: m_axis_tready <= (sink_cycle % 7 == 0);
    endcase
  end

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_timer(input logic [DATA_W-1:0] ss, input logic [DATA_W-1:0] su,
                           input logic [DATA_W-1:0] ps, input logic [DATA_W-1:0] pu,
                           input logic [DATA_W-1:0] tk);
    write_reg(REG_START_SECONDS, ss);
    write_reg(REG_START_MICROS, su);
    write_reg(REG_PERIOD_SECONDS, ps);
    write_reg(REG_PERIOD_MICROS, pu);
    write_reg(REG_CLOCK_TICK_MICROS, tk);
    cfg_valid <= 1'b0;
  endtask

  // send one request; hold valid across a burst, drop it for a gap between
  task automatic send_request(input logic op, input logic [USEC_W-1:0] elapsed);
    if (burst_left == 0) begin
      if (s_axis_tvalid) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= 24'(elapsed);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
  endtask

  // hold off until every outstanding request has produced its result
  task automatic wait_drained();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_seconds();
    case ($urandom_range(15))
      0: return MAX_SECONDS;
      1: return MAX_SECONDS + 1;
      2: return DATA_W'($urandom);
      3: return '0;
      default: return DATA_W'($urandom_range(3));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_micros();
    logic [USEC_W-1:0] us;
    case ($urandom_range(15))
      0: us = '0;
      1: us = MAX_MICROS;
      2: us = USEC_W'($urandom_range(1000000, (1 << USEC_W) - 1));
      3: us = USEC_W'($urandom_range(1, 50));
      default: us = USEC_W'($urandom_range(0, 999999));
    endcase
    // junk in the unused upper bits must be dropped by the register
    if ($urandom_range(3) == 0)
      return {(DATA_W - USEC_W)'($urandom), us};
    return DATA_W'(us);
  endfunction

  function automatic logic [DATA_W-1:0] pick_tick();
    case ($urandom_range(9))
      0: return '0;
      1: return DATA_W'(MAX_MICROS);
      2: return DATA_W'({USEC_W{1'b1}});
      3: return DATA_W'($urandom_range(1, 999999));
      4: return DATA_W'(TICK_RESET);
      default: return DATA_W'($urandom_range(1, 200000));
    endcase
  endfunction

  function automatic logic [USEC_W-1:0] pick_elapsed();
    case ($urandom_range(15))
      0: return '0;
      1: return MAX_MICROS;
      2: return USEC_W'($urandom_range(1000000, (1 << USEC_W) - 1));
      3: return USEC_W'($urandom);
      4: return USEC_W'($urandom_range(1, 50));
      default: return USEC_W'($urandom_range(0, 999999));
    endcase
  endfunction

  task automatic shuffle_config();
    if ($urandom_range(3) != 0) write_reg(REG_START_SECONDS, pick_seconds());
    if ($urandom_range(3) != 0) write_reg(REG_START_MICROS, pick_micros());
    if ($urandom_range(5) == 0) begin
      // one-shot
      write_reg(REG_PERIOD_SECONDS, '0);
      write_reg(REG_PERIOD_MICROS, '0);
    end else begin
      if ($urandom_range(3) != 0) write_reg(REG_PERIOD_SECONDS, pick_seconds());
      if ($urandom_range(3) != 0) write_reg(REG_PERIOD_MICROS, pick_micros());
    end
    if ($urandom_range(2) == 0) write_reg(REG_CLOCK_TICK_MICROS, pick_tick());
    if ($urandom_range(7) == 0)
      write_reg(INDEX_W'(REG_CLOCK_TICK_MICROS + $urandom_range(1, 3)), DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // ticks on a zero timer, then a load of an all-zero configuration
    wait_drained();
    send_request(OP_TICK, '0);
    send_request(OP_TICK, {USEC_W{1'b1}});
    send_request(OP_LOAD, USEC_W'($urandom));

    // overshoot equal to the period: stop at zero; unused indexes ignored
    wait_drained();
    write_reg(INDEX_W'(REG_CLOCK_TICK_MICROS + 1), DATA_W'($urandom));
    write_reg(INDEX_W'(REG_CLOCK_TICK_MICROS + 3), {DATA_W{1'b1}});
    set_timer(0, 500, 0, 100, 0);
    send_request(OP_LOAD, '0);
    send_request(OP_TICK, USEC_W'(600));
    send_request(OP_TICK, USEC_W'(5));

    // overshoot beyond the period, then an exact hit
    wait_drained();
    set_timer(0, 500, 0, 50, 1);
    send_request(OP_LOAD, '0);
    send_request(OP_TICK, USEC_W'(700));
    send_request(OP_TICK, USEC_W'(20));
    send_request(OP_TICK, USEC_W'(30));

    // borrow from seconds and clamp of an out-of-range elapsed value
    wait_drained();
    set_timer(1, 0, 2, 0, DATA_W'(TICK_RESET));
    send_request(OP_LOAD, '0);
    send_request(OP_TICK, {USEC_W{1'b1}});
    send_request(OP_TICK, USEC_W'(1));
    send_request(OP_TICK, MAX_MICROS);
    send_request(OP_TICK, '0);

    // round-up to the tick at the top of its range, then tick and start above range
    wait_drained();
    set_timer(0, 1, 0, 5, DATA_W'(MAX_MICROS));
    send_request(OP_LOAD, '0);
    send_request(OP_TICK, MAX_MICROS);
    wait_drained();
    set_timer(0, {DATA_W{1'b1}}, 0, 5, {DATA_W{1'b1}});
    send_request(OP_LOAD, '0);

    // loads at the edges of the ranges, rejected just beyond them
    wait_drained();
    set_timer(MAX_SECONDS + 1, 0, 0, 0, DATA_W'(TICK_RESET));
    send_request(OP_LOAD, '0);
    wait_drained();
    set_timer(MAX_SECONDS, DATA_W'(MAX_MICROS), MAX_SECONDS, DATA_W'(MAX_MICROS), 1);
    send_request(OP_LOAD, '0);
    wait_drained();
    write_reg(REG_START_MICROS, DATA_W'(1000000));
    cfg_valid <= 1'b0;
    send_request(OP_LOAD, '0);
    wait_drained();
    set_timer(0, 0, 0, DATA_W'({USEC_W{1'b1}}), 1);
    send_request(OP_LOAD, '0);
    wait_drained();
    set_timer(0, 0, {DATA_W{1'b1}}, 0, 1);
    send_request(OP_LOAD, '0);

    // period rewritten after the load: the latched one must be used
    wait_drained();
    set_timer(0, 300, 0, 400, 0);
    send_request(OP_LOAD, '0);
    wait_drained();
    write_reg(REG_PERIOD_MICROS, 100);
    cfg_valid <= 1'b0;
    send_request(OP_TICK, USEC_W'(300));

    // random phases, each under a fresh configuration
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      shuffle_config();
      if ($urandom_range(4) != 0) begin
        send_request(OP_LOAD, USEC_W'($urandom));
        sent++;
      end
      phase_len = $urandom_range(40, 120);
      repeat (phase_len) begin
        if ($urandom_range(99) < 6)
          send_request(OP_LOAD, USEC_W'($urandom));
        else
          send_request(OP_TICK, pick_elapsed());
        sent++;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("** interval_timer_decrement: PASSED **");
    else
      $display("** interval_timer_decrement: FAILED **");
    $finish;
  end

endmodule
